// ----- src/point_in_polygon_test_top_assert.svh -----
// Assertion macros for the point-in-polygon test block.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef POINT_IN_POLYGON_TEST_TOP_ASSERT_SVH
`define POINT_IN_POLYGON_TEST_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PIP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PIP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PIP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define PIP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- src/pip_pkg.sv -----
// Shared constants and types for the point-in-polygon test block.
// No dependencies; imported by every module of the block except pip_ram.
package pip_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

    localparam int REG_W        = 7;     // vertex_count register
    localparam int VIDX_W       = 6;     // vertex_index field
    localparam int COORD_W      = 32;    // Q16.16 coordinate
    localparam int SUM_W        = COORD_W + 1;   // position + offset, exact
    localparam int DIFF_W       = SUM_W + 1;     // point minus vertex
    localparam int CHUNK_W      = 17;    // multiplier operand split
    localparam int MB_W         = CHUNK_W + 1;
    localparam int PROD_W       = DIFF_W + MB_W;
    localparam int ACC_W        = 70;    // holds a 34x34 product difference

    localparam int S_TDATA_W    = 136;
    localparam int M_TDATA_W    = 8;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef struct packed {
        logic vld;   // issue a partial product
        logic clr;   // start a new sum
        logic neg;   // subtract instead of add
        logic hi;    // weight by 2^CHUNK_W
    } t_mac_op;

endpackage

// ----- src/point_in_polygon_test_top.sv -----
// Point-in-polygon test: a query item walks the polygon edges, skipping edges that miss the
// point's y, and goes straight to its result at zero vertices; the result then waits for the
// output register to free up. Edge work is bound by the shared 34x18 MAC (four partial products
// per straddling edge) and the vertex stores' single read port; input not ready meanwhile.
// Synchronous active-low reset clears vertex count, sequencer and result valid.
module point_in_polygon_test_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // tdata: vertex_index[5:0], coord_x, coord_y, offset_x, offset_y, 2 pad bits
    input  logic [pip_pkg::S_TDATA_W-1:0]     i_s_tdata,
    // tuser: cmd
    input  logic                              i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // tdata: inside_res, 7 pad bits
    output logic [pip_pkg::M_TDATA_W-1:0]     o_m_tdata,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pip_pkg::REG_W-1:0]         i_cfg_data
);
    import pip_pkg::*;

    logic [REG_W-1:0]           r_count;
    logic [CNT_W-1:0]           w_count;
    logic                       w_accept;
    logic                       w_we;
    logic                       w_start;
    logic                       w_idle;
    logic                       w_res;
    logic [VIDX_W-1:0]          w_vidx;
    logic signed [COORD_W-1:0]  w_cx, w_cy, w_ox, w_oy;
    logic signed [SUM_W-1:0]    w_px, w_py;
    logic [IDX_W-1:0]           w_raddr;
    logic [COORD_W-1:0]         w_rd_x, w_rd_y;

    assign w_vidx = i_s_tdata[5:0];
    assign w_cx   = $signed(i_s_tdata[37:6]);
    assign w_cy   = $signed(i_s_tdata[69:38]);
    assign w_ox   = $signed(i_s_tdata[101:70]);
    assign w_oy   = $signed(i_s_tdata[133:102]);

    assign w_px = SUM_W'(w_cx) + SUM_W'(w_ox);
    assign w_py = SUM_W'(w_cy) + SUM_W'(w_oy);

    assign o_s_tready = w_idle;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_we       = w_accept && (i_s_tuser == CMD_WRITE) && (int'(w_vidx) < MAX_VERTICES);
    assign w_start    = w_accept && (i_s_tuser == CMD_QUERY);

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_count <= i_cfg_data;
        end
    end

    // counts above the store depth use the whole store
    assign w_count = (int'(r_count) > MAX_VERTICES) ? CNT_W'(MAX_VERTICES) : CNT_W'(r_count);

    pip_ram #(.WIDTH(COORD_W), .DEPTH(MAX_VERTICES)) u_ram_x (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (IDX_W'(w_vidx)),
        .i_wdata (w_cx),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_x)
    );

    pip_ram #(.WIDTH(COORD_W), .DEPTH(MAX_VERTICES)) u_ram_y (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (IDX_W'(w_vidx)),
        .i_wdata (w_cy),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_y)
    );

    pip_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_px        (w_px),
        .i_py        (w_py),
        .i_count     (w_count),
        .i_rd_x      ($signed(w_rd_x)),
        .i_rd_y      ($signed(w_rd_y)),
        .o_raddr     (w_raddr),
        .o_idle      (w_idle),
        .o_res_valid (o_m_tvalid),
        .o_res       (w_res),
        .i_res_ready (i_m_tready)
    );

    assign o_m_tdata = {{(M_TDATA_W-1){1'b0}}, w_res};

endmodule

// ----- src/pip_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pip_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/pip_mac.sv -----
// Shared multiply-accumulate unit: 34x18 signed product, registered, then
// added to or subtracted from a 70-bit sum. Depends on pip_pkg.
module pip_mac (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  pip_pkg::t_mac_op                      i_op,
    input  logic signed [pip_pkg::DIFF_W-1:0]     i_a,
    input  logic signed [pip_pkg::MB_W-1:0]       i_b,
    output logic signed [pip_pkg::ACC_W-1:0]      o_acc
);
    import pip_pkg::*;

    t_mac_op                   r_op;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [ACC_W-1:0]   n_acc;
    logic signed [ACC_W-1:0]   w_ext;
    logic signed [ACC_W-1:0]   w_term;
    logic signed [ACC_W-1:0]   w_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op <= '0;
        end else begin
            r_op <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        if (r_op.vld) begin
            r_acc <= n_acc;
        end
    end

    always_comb begin
        w_ext  = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
        w_term = r_op.hi ? (w_ext <<< CHUNK_W) : w_ext;
        w_base = r_op.clr ? '0 : r_acc;
        n_acc  = r_op.neg ? (w_base - w_term) : (w_base + w_term);
    end

    assign o_acc = r_acc;

endmodule

// ----- src/pip_ctrl.sv -----
// Query sequencer: walks the polygon edges, drives the vertex read port and
// the shared multiply-accumulate unit, holds the result register.
// Depends on pip_pkg, pip_mac and the assertion header.
`include "point_in_polygon_test_top_assert.svh"
module pip_ctrl (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [pip_pkg::SUM_W-1:0]     i_px,
    input  logic signed [pip_pkg::SUM_W-1:0]     i_py,
    input  logic [pip_pkg::CNT_W-1:0]            i_count,
    input  logic signed [pip_pkg::COORD_W-1:0]   i_rd_x,
    input  logic signed [pip_pkg::COORD_W-1:0]   i_rd_y,
    output logic [pip_pkg::IDX_W-1:0]            o_raddr,
    output logic                                 o_idle,
    output logic                                 o_res_valid,
    output logic                                 o_res,
    input  logic                                 i_res_ready
);
    import pip_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RDJ  = 4'd1;
    localparam logic [3:0] S_CAPJ = 4'd2;
    localparam logic [3:0] S_CAPI = 4'd3;
    localparam logic [3:0] S_RDI  = 4'd4;
    localparam logic [3:0] S_M0   = 4'd5;
    localparam logic [3:0] S_M1   = 4'd6;
    localparam logic [3:0] S_M2   = 4'd7;
    localparam logic [3:0] S_M3   = 4'd8;
    localparam logic [3:0] S_DRN  = 4'd9;
    localparam logic [3:0] S_EVAL = 4'd10;
    localparam logic [3:0] S_FIN  = 4'd11;

    logic [3:0]                 r_state, n_state;
    logic [IDX_W-1:0]           r_idx, n_idx;
    logic signed [SUM_W-1:0]    r_px, n_px, r_py, n_py;
    logic signed [COORD_W-1:0]  r_xj, n_xj, r_yj, n_yj, r_xi, n_xi, r_yi, n_yi;
    logic signed [DIFF_W-1:0]   r_da, n_da, r_dpy, n_dpy;
    logic signed [SUM_W-1:0]    r_dx, n_dx, r_dy, n_dy;
    logic                       r_last, n_last;
    logic                       r_inside, n_inside;
    logic                       r_out_valid, n_out_valid;
    logic                       r_out_data, n_out_data;

    logic                       w_last;
    logic                       w_straddle;
    logic                       w_left;
    logic                       w_out_free;
    logic signed [DIFF_W-1:0]   w_da, w_dpy;
    logic signed [SUM_W-1:0]    w_dx, w_dy;
    t_mac_op                    w_mop;
    logic signed [DIFF_W-1:0]   w_ma;
    logic signed [DIFF_W-1:0]   w_mb_src;
    logic signed [MB_W-1:0]     w_mb;
    logic signed [ACC_W-1:0]    w_acc;

    pip_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (w_mop),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .o_acc   (w_acc)
    );

    // edge terms from the freshly read vertex i and the held vertex j
    always_comb begin
        w_da       = DIFF_W'(r_px) - DIFF_W'(i_rd_x);
        w_dpy      = DIFF_W'(r_py) - DIFF_W'(i_rd_y);
        w_dx       = SUM_W'(r_xj) - SUM_W'(i_rd_x);
        w_dy       = SUM_W'(r_yj) - SUM_W'(i_rd_y);
        w_straddle = (SUM_W'(i_rd_y) > r_py) != (SUM_W'(r_yj) > r_py);
        w_last     = (CNT_W'(r_idx) == (i_count - CNT_W'(1)));
        w_out_free = !r_out_valid || i_res_ready;
        // diff = (px-xi)*dy - (xj-xi)*(py-yi); point is left when the sign
        // of diff opposes the sign of dy
        w_left     = r_dy[SUM_W-1] ? (!w_acc[ACC_W-1] && (w_acc != '0))
                                   : w_acc[ACC_W-1];
    end

    // operand schedule: low then high chunk of dy, low then high chunk of py-yi
    always_comb begin
        w_mop    = '0;
        w_ma     = r_da;
        w_mb_src = DIFF_W'(r_dy);
        case (r_state)
            S_M0: begin
                w_mop = '{vld: 1'b1, clr: 1'b1, neg: 1'b0, hi: 1'b0};
            end
            S_M1: begin
                w_mop = '{vld: 1'b1, clr: 1'b0, neg: 1'b0, hi: 1'b1};
            end
            S_M2: begin
                w_mop    = '{vld: 1'b1, clr: 1'b0, neg: 1'b1, hi: 1'b0};
                w_ma     = DIFF_W'(r_dx);
                w_mb_src = r_dpy;
            end
            S_M3: begin
                w_mop    = '{vld: 1'b1, clr: 1'b0, neg: 1'b1, hi: 1'b1};
                w_ma     = DIFF_W'(r_dx);
                w_mb_src = r_dpy;
            end
            default: begin
                w_mop = '0;
            end
        endcase
        w_mb = w_mop.hi ? MB_W'($signed(w_mb_src[DIFF_W-1:CHUNK_W]))
                        : $signed({1'b0, w_mb_src[CHUNK_W-1:0]});
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_px        = r_px;
        n_py        = r_py;
        n_xj        = r_xj;
        n_yj        = r_yj;
        n_xi        = r_xi;
        n_yi        = r_yi;
        n_da        = r_da;
        n_dx        = r_dx;
        n_dy        = r_dy;
        n_dpy       = r_dpy;
        n_last      = r_last;
        n_inside    = r_inside;
        n_out_valid = r_out_valid && !i_res_ready;
        n_out_data  = r_out_data;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_px     = i_px;
                    n_py     = i_py;
                    n_inside = 1'b0;
                    n_idx    = '0;
                    n_state  = (i_count == '0) ? S_FIN : S_RDJ;
                end
            end
            S_RDJ: begin
                n_state = S_CAPJ;
            end
            S_CAPJ: begin
                n_xj    = i_rd_x;
                n_yj    = i_rd_y;
                n_state = S_CAPI;
            end
            S_CAPI: begin
                n_xi   = i_rd_x;
                n_yi   = i_rd_y;
                n_da   = w_da;
                n_dx   = w_dx;
                n_dy   = w_dy;
                n_dpy  = w_dpy;
                n_last = w_last;
                n_idx  = r_idx + IDX_W'(1);
                if (w_straddle) begin
                    n_state = S_M0;
                end else begin
                    n_xj    = i_rd_x;
                    n_yj    = i_rd_y;
                    n_state = w_last ? S_FIN : S_RDI;
                end
            end
            S_RDI: begin
                n_state = S_CAPI;
            end
            S_M0: begin
                n_state = S_M1;
            end
            S_M1: begin
                n_state = S_M2;
            end
            S_M2: begin
                n_state = S_M3;
            end
            S_M3: begin
                n_state = S_DRN;
            end
            S_DRN: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (w_left) begin
                    n_inside = !r_inside;
                end
                n_xj    = r_xi;
                n_yj    = r_yi;
                n_state = r_last ? S_FIN : S_CAPI;
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_inside;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_px       <= n_px;
        r_py       <= n_py;
        r_xj       <= n_xj;
        r_yj       <= n_yj;
        r_xi       <= n_xi;
        r_yi       <= n_yi;
        r_da       <= n_da;
        r_dx       <= n_dx;
        r_dy       <= n_dy;
        r_dpy      <= n_dpy;
        r_last     <= n_last;
        r_inside   <= n_inside;
        r_out_data <= n_out_data;
    end

    // first read of a query fetches the closing vertex (count - 1)
    assign o_raddr     = (r_state == S_RDJ) ? IDX_W'(i_count - CNT_W'(1)) : r_idx;
    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out_data;

    `PIP_ASSERT_IMP(a_dy_nonzero, i_clk, i_rst_n, r_state == S_M0, r_dy != '0, "crossing edge with flat dy")
    `PIP_ASSERT_NXT(a_last_edge_ends, i_clk, i_rst_n, (r_state == S_EVAL) && r_last, r_state == S_FIN, "last edge did not finish query")
    `PIP_ASSERT_NXT(a_result_loaded, i_clk, i_rst_n, (r_state == S_FIN) && w_out_free, r_out_valid && (r_out_data == $past(r_inside)), "result not loaded from inside flag")

endmodule

// ----- tb/sv/tb_point_in_polygon_test_top.sv -----
// Self-checking testbench for point_in_polygon_test_top: vertex writes and
// containment queries over stream ports, checked against a crossing-number predictor.
// Depends on pip_pkg and the block's RTL only.
module tb_point_in_polygon_test_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pip_pkg::*;

    typedef struct {
        logic                      cmd;
        logic [VIDX_W-1:0]         slot;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] ox;
        logic signed [COORD_W-1:0] oy;
    } t_pip_cmd;

    localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;
    localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7fff_ffff;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 600;

    logic                   i_clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tready = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic [REG_W-1:0]       cfg_data = '0;
    logic                   s_tready;
    logic                   m_tvalid;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_ready;

    point_in_polygon_test_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor state
    longint     vx_mem [MAX_VERTICES];
    longint     vy_mem [MAX_VERTICES];
    logic [REG_W-1:0] poly_count = '0;
    logic       inside_due [$];
    t_pip_cmd   pending_cmds [$];
    t_pip_cmd   drv_item;

    // stimulus-side copy of the vertex stores
    longint     plan_vx [MAX_VERTICES];
    longint     plan_vy [MAX_VERTICES];

    int tx_idle_pct = 29;
    int rx_idle_pct = 64;
    int rx_hold_req = 0;
    int rx_hold_left = 0;
    int err_cnt = 0;
    int n_writes = 0;
    int n_queries = 0;
    int n_inside = 0;
    int n_cfg = 0;

    function automatic logic crossing_parity(longint px, longint py);
        int n;
        int j;
        logic odd;
        longint xi, yi, xj, yj, dy;
        logic signed [127:0] lhs, rhs;
        n = (poly_count > MAX_VERTICES) ? MAX_VERTICES : int'(poly_count);
        odd = 1'b0;
        for (int i = 0; i < n; i++) begin
            j  = (i == 0) ? n - 1 : i - 1;
            xi = vx_mem[i];
            yi = vy_mem[i];
            xj = vx_mem[j];
            yj = vy_mem[j];
            if ((yi > py) != (yj > py)) begin
                dy  = yj - yi;
                lhs = (px - xi) * dy;
                rhs = (xj - xi) * (py - yi);
                // compare sense flips with the sign of the edge's dy
                if (dy > 0 ? (lhs < rhs) : (rhs < lhs))
                    odd = ~odd;
            end
        end
        return odd;
    endfunction

    function automatic void apply_item(t_pip_cmd it);
        logic res;
        if (it.cmd == CMD_WRITE) begin
            vx_mem[it.slot] = longint'(it.cx);
            vy_mem[it.slot] = longint'(it.cy);
            n_writes++;
        end else begin
            res = crossing_parity(longint'(it.cx) + longint'(it.ox),
                                  longint'(it.cy) + longint'(it.oy));
            inside_due.push_back(res);
            n_queries++;
            if (res)
                n_inside++;
        end
    endfunction

    function automatic void flag_error(string msg);
        if (err_cnt < 10)
            $display("ERROR @%0t: %s", $realtime, msg);
        err_cnt++;
    endfunction

    // input driver
    always @(posedge i_clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid)
                apply_item(drv_item);
            if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                drv_item = pending_cmds.pop_front();
                s_tdata  <= {2'b00, drv_item.oy, drv_item.ox, drv_item.cy, drv_item.cx,
                             drv_item.slot};
                s_tuser  <= drv_item.cmd;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus an occasional long hold-off
    always @(posedge i_clk) begin
        if (rx_hold_req != 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
        end
        if (rx_hold_left != 0) begin
            rx_hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        logic want;
        if (rst_n && m_tvalid && m_tready) begin
            if (inside_due.size() == 0) begin
                flag_error($sformatf("result %0b with no query outstanding", m_tdata[0]));
            end else begin
                want = inside_due.pop_front();
                if (m_tdata[0] !== want)
                    flag_error($sformatf("inside_res expected %0b got %0b", want, m_tdata[0]));
            end
        end
    end

    function automatic logic signed [COORD_W-1:0] sat32(longint v);
        if (v > longint'(C_MAX))
            return C_MAX;
        if (v < longint'(C_MIN))
            return C_MIN;
        return v[COORD_W-1:0];
    endfunction

    // random value spread over about +/- 2^k
    function automatic longint spread(int k);
        return longint'(int'($urandom)) >>> (31 - k);
    endfunction

    function automatic void queue_write(int slot, logic signed [COORD_W-1:0] x,
                                        logic signed [COORD_W-1:0] y);
        t_pip_cmd it;
        it.cmd  = CMD_WRITE;
        it.slot = slot[VIDX_W-1:0];
        it.cx   = x;
        it.cy   = y;
        it.ox   = $urandom;   // ignored on a write
        it.oy   = $urandom;
        plan_vx[slot] = longint'(x);
        plan_vy[slot] = longint'(y);
        pending_cmds.push_back(it);
    endfunction

    function automatic void queue_query(logic signed [COORD_W-1:0] x,
                                        logic signed [COORD_W-1:0] y,
                                        logic signed [COORD_W-1:0] dx,
                                        logic signed [COORD_W-1:0] dy);
        t_pip_cmd it;
        it.cmd  = CMD_QUERY;
        it.slot = $urandom;
        it.cx   = x;
        it.cy   = y;
        it.ox   = dx;
        it.oy   = dy;
        pending_cmds.push_back(it);
    endfunction

    // aim a query at (tx, ty), split randomly into position plus offset
    function automatic void queue_aimed(longint tx, longint ty);
        longint offx, offy;
        offx = spread($urandom_range(0, 31));
        offy = spread($urandom_range(0, 31));
        queue_query(sat32(tx - offx), sat32(ty - offy), offx[31:0], offy[31:0]);
    endfunction

    task automatic settle();
        while (pending_cmds.size() != 0 || s_tvalid || inside_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_vertex_count(logic [REG_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        poly_count = v;
        n_cfg++;
    endtask

    // one polygon: write all used slots, then aimed queries mixed with noise
    task automatic polygon_run(logic [REG_W-1:0] cnt, int n_q);
        int n, k, sel, v;
        longint ctr_x, ctr_y;
        n     = (cnt > MAX_VERTICES) ? MAX_VERTICES : int'(cnt);
        k     = $urandom_range(4, 31);
        ctr_x = longint'(int'($urandom));
        ctr_y = longint'(int'($urandom));
        for (int s = 0; s < n; s++)
            queue_write(s, sat32(ctr_x + spread(k)), sat32(ctr_y + spread(k)));
        for (int q = 0; q < n_q; q++) begin
            sel = $urandom_range(0, 19);
            v   = (n == 0) ? 0 : $urandom_range(0, n - 1);
            if (sel < 12)
                queue_aimed(ctr_x + spread(k), ctr_y + spread(k));
            else if (sel < 15 && n != 0)
                queue_aimed(ctr_x + spread(k), plan_vy[v]);   // on a vertex's y
            else if (sel < 17 && n != 0)
                queue_aimed(plan_vx[v], plan_vy[v]);          // exactly on a vertex
            else if (sel < 19)
                queue_query($urandom, $urandom, $urandom, $urandom);
            else
                queue_write($urandom_range(0, MAX_VERTICES - 1), $urandom, $urandom);
        end
    endtask

    initial begin
        logic [REG_W-1:0] counts [14];
        counts = '{7'd64, 7'd5, 7'd127, 7'd3, 7'd1, 7'd2, 7'd0, 7'd9,
                   7'd12, 7'd4, 7'd100, 7'd7, 7'd6, 7'd65};
        repeat (10) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // no vertices in use: always outside
        queue_write(63, C_MAX, C_MIN);
        queue_query(C_MAX, C_MAX, C_MAX, C_MAX);
        queue_query(C_MIN, C_MIN, C_MIN, C_MIN);
        queue_query(32'sd0, 32'sd0, 32'sd0, 32'sd0);
        settle();

        // square at the coordinate extremes
        write_vertex_count(7'd4);
        queue_write(0, C_MIN, C_MIN);
        queue_write(1, C_MAX, C_MIN);
        queue_write(2, C_MAX, C_MAX);
        queue_write(3, C_MIN, C_MAX);
        queue_query(32'sd0, 32'sd0, 32'sd0, 32'sd0);
        queue_query(C_MAX, C_MAX, C_MAX, C_MAX);        // sum past 32 bits
        queue_query(C_MIN, C_MIN, C_MIN, C_MIN);
        queue_query(32'sd0, C_MIN, 32'sd0, 32'sd0);     // on the bottom edge's y
        queue_query(C_MIN, 32'sd0, 32'sd1, 32'sd0);     // just right of left edge
        queue_query(C_MAX, 32'sd5, -32'sd1, 32'sd0);
        queue_query(C_MAX, C_MIN, C_MIN, C_MAX);        // offsets cancel to (-1,-1)
        queue_query(C_MIN, C_MAX, 32'sd0, -32'sd1);
        settle();

        for (int seg = 0; seg < 14; seg++) begin
            tx_idle_pct = (seg < 5) ? 29 : (seg < 10) ? 64 : 0;
            rx_idle_pct = (seg < 5) ? 64 : (seg < 10) ? 29 : 0;
            write_vertex_count(counts[seg]);
            if (seg == 1)
                rx_hold_req = HOLD_CYCLES;
            polygon_run(counts[seg], 13);
            settle();
        end

        if (inside_due.size() != 0)
            flag_error($sformatf("%0d results never arrived", inside_due.size()));
        $display("covered %0d vertex writes, %0d queries (%0d inside), %0d vertex_count writes",
                 n_writes, n_queries, n_inside, n_cfg);
        $display("counts 0 through 127, offset sums past 32 bits, %0d mismatches", err_cnt);
        if (err_cnt == 0)
            $display("tb_point_in_polygon_test_top passed");
        else
            $display("tb_point_in_polygon_test_top failed");
        $finish;
    end

    initial begin
        #8_000_000;
        $display("tb_point_in_polygon_test_top failed");
        $finish;
    end

endmodule
